// ===== rtl/core/u16u8_pkg.sv =====
// Shared types, codes and the UTF-8 byte encoder for the UTF-16 to UTF-8 transcoder.
// Used by u16u8_step, u16u8_drain, utf16_to_utf8_transcoder and the dv files; depends on nothing else.
package u16u8_pkg;

  // Default width of the written-byte counter.
  localparam int COUNT_WIDTH_DEF = 16;

  // Configuration register indexes.
  localparam logic REG_BYTE_ORDER_MODE = 1'b0;
  localparam logic REG_OUT_CAPACITY    = 1'b1;

  // Byte order modes.
  localparam logic [1:0] MODE_BIG    = 2'd0;
  localparam logic [1:0] MODE_LITTLE = 2'd1;
  localparam logic [1:0] MODE_DETECT = 2'd2;

  // Status codes carried by results.
  localparam logic [1:0] ST_RUNNING = 2'd0;
  localparam logic [1:0] ST_VALID   = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  // Most results one request can cause, and the index width over them.
  localparam int MAX_RESULTS = 7;
  localparam int RES_IDX_W   = $clog2(MAX_RESULTS + 1);

  // Byte-order mark bytes.
  localparam logic [7:0] BOM_FE = 8'hFE;
  localparam logic [7:0] BOM_FF = 8'hFF;

  // All results for one request: data bytes first, then an optional status-only result.
  typedef struct packed {
    logic [MAX_RESULTS-1:0][7:0] data;
    logic [RES_IDX_W-1:0]        ndata;
    logic                        fin;
    logic [1:0]                  fstat;
  } run_t;

  // One encoded code point: up to four bytes, leading byte in entry 0.
  typedef struct packed {
    logic [3:0][7:0] b;
    logic [2:0]      n;
  } enc_t;

  // UTF-8 encoding of a code point up to 21 bits.
  function automatic enc_t utf8_encode(input logic [20:0] cp);
    enc_t e;
    e = '0;
    if (cp < 21'h80) begin
      e.n    = 3'd1;
      e.b[0] = cp[7:0];
    end else if (cp < 21'h800) begin
      e.n    = 3'd2;
      e.b[0] = {3'b110, cp[10:6]};
      e.b[1] = {2'b10, cp[5:0]};
    end else if (cp < 21'h10000) begin
      e.n    = 3'd3;
      e.b[0] = {4'b1110, cp[15:12]};
      e.b[1] = {2'b10, cp[11:6]};
      e.b[2] = {2'b10, cp[5:0]};
    end else begin
      e.n    = 3'd4;
      e.b[0] = {5'b11110, cp[20:18]};
      e.b[1] = {2'b10, cp[17:12]};
      e.b[2] = {2'b10, cp[11:6]};
      e.b[3] = {2'b10, cp[5:0]};
    end
    return e;
  endfunction

endpackage

// ===== rtl/core/u16u8_step.sv =====
// Per-request decode: holds the buffer state and turns one registered UTF-16 unit
// into a run of UTF-8 results. Depends on u16u8_pkg.
module u16u8_step #(
  parameter int COUNT_WIDTH = u16u8_pkg::COUNT_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  logic [7:0]        first_byte,
  input  logic [7:0]        second_byte,
  input  logic              first_unit,
  input  logic              last_unit,
  input  logic [1:0]        mode,
  input  logic [15:0]       capacity,
  output u16u8_pkg::run_t   run
);
  import u16u8_pkg::*;

  localparam int CMPW = ((COUNT_WIDTH > 16) ? COUNT_WIDTH : 16) + 1;

  logic                   aw_r, aw_nxt, aw_e;
  logic                   ord_r, ord_nxt, ord_e;
  logic                   hp_r, hp_nxt, hp_e;
  logic [9:0]             hb_r, hb_nxt, hb_e;
  logic [COUNT_WIDTH-1:0] bw_r, bw_nxt, bw_e;
  logic                   stp_r, stp_nxt, stp_e;

  logic                   zero_unit;
  logic [15:0]            unit;
  logic                   is_low, is_high;
  logic [20:0]            cp_pair, cp_b;
  enc_t                   enc_a, enc_b;
  logic [COUNT_WIDTH-1:0] bw_a, bw_base, bw_b;
  logic                   cap_a_ok, cap_b_ok;
  logic                   use_a;
  logic [2:0]             nb;
  logic                   fin;
  logic [1:0]             fstat;

  // State as seen by this request: a buffer start clears it first.
  always_comb begin
    if (first_unit) begin
      aw_e  = (mode >= MODE_DETECT);
      ord_e = (mode == MODE_LITTLE);
      hp_e  = 1'b0;
      hb_e  = '0;
      bw_e  = '0;
      stp_e = 1'b0;
    end else begin
      aw_e  = aw_r;
      ord_e = ord_r;
      hp_e  = hp_r;
      hb_e  = hb_r;
      bw_e  = bw_r;
      stp_e = stp_r;
    end
  end

  // Unit assembly, surrogate classes and the two candidate codes.
  always_comb begin
    zero_unit = (first_byte == 8'd0) && (second_byte == 8'd0);
    unit      = ord_e ? {second_byte, first_byte} : {first_byte, second_byte};
    is_low    = (unit[15:10] == 6'b110111);
    is_high   = (unit[15:10] == 6'b110110);
    cp_pair   = 21'h10000 + {1'b0, hb_e, 10'd0} + {11'd0, unit[9:0]};
    cp_b      = (hp_e && is_low) ? cp_pair : {5'd0, unit};
    enc_a     = utf8_encode({5'd0, 6'b110110, hb_e});
    enc_b     = utf8_encode(cp_b);
  end

  // Capacity checks: the held surrogate goes out first, then the unit's own code.
  always_comb begin
    bw_a     = bw_e + COUNT_WIDTH'(3);
    cap_a_ok = (CMPW'(bw_e) + CMPW'(3)) < CMPW'(capacity);
    bw_base  = (hp_e && !is_low) ? bw_a : bw_e;
    bw_b     = bw_base + COUNT_WIDTH'(enc_b.n);
    cap_b_ok = (CMPW'(bw_base) + CMPW'(enc_b.n)) < CMPW'(capacity);
  end

  // Decide the results and the next state.
  always_comb begin
    aw_nxt  = aw_e;
    ord_nxt = ord_e;
    hp_nxt  = hp_e;
    hb_nxt  = hb_e;
    bw_nxt  = bw_e;
    stp_nxt = stp_e;
    use_a   = 1'b0;
    nb      = 3'd0;
    fin     = 1'b0;
    fstat   = ST_RUNNING;
    if (!stp_e) begin
      hp_nxt = 1'b0;
      if (aw_e) begin
        // First unit in detect mode is the byte-order mark.
        aw_nxt = 1'b0;
        if (first_byte == BOM_FF && second_byte == BOM_FE) begin
          ord_nxt = 1'b1;
        end else if (first_byte == BOM_FE && second_byte == BOM_FF) begin
          ord_nxt = 1'b0;
        end else begin
          fin   = 1'b1;
          fstat = ST_INVALID;
        end
        if (!fin && last_unit) begin
          fin   = 1'b1;
          fstat = ST_VALID;
        end
      end else if (zero_unit) begin
        // End of string: flush a held surrogate, then finish.
        if (hp_e && !cap_a_ok) begin
          fin   = 1'b1;
          fstat = ST_INVALID;
        end else begin
          if (hp_e) begin
            use_a  = 1'b1;
            bw_nxt = bw_a;
          end
          fin   = 1'b1;
          fstat = ST_VALID;
        end
      end else if (hp_e && is_low) begin
        // Surrogate pair becomes one four-byte code.
        if (!cap_b_ok) begin
          fin   = 1'b1;
          fstat = ST_INVALID;
        end else begin
          nb     = enc_b.n;
          bw_nxt = bw_b;
          if (last_unit) begin
            fin   = 1'b1;
            fstat = ST_VALID;
          end
        end
      end else if (hp_e && !cap_a_ok) begin
        fin   = 1'b1;
        fstat = ST_INVALID;
      end else begin
        // Lone held surrogate first, then this unit.
        use_a  = hp_e;
        bw_nxt = bw_base;
        if (is_high) begin
          if (last_unit) begin
            fin   = 1'b1;
            fstat = ST_INVALID;
          end else begin
            hp_nxt = 1'b1;
            hb_nxt = unit[9:0];
          end
        end else if (!cap_b_ok) begin
          fin   = 1'b1;
          fstat = ST_INVALID;
        end else begin
          nb     = enc_b.n;
          bw_nxt = bw_b;
          if (last_unit) begin
            fin   = 1'b1;
            fstat = ST_VALID;
          end
        end
      end
      if (fin) begin
        stp_nxt = 1'b1;
        hp_nxt  = 1'b0;
      end
    end
  end

  // Pack the held surrogate's bytes ahead of the unit's bytes.
  always_comb begin
    run = '0;
    if (use_a) begin
      run.data[0] = enc_a.b[0];
      run.data[1] = enc_a.b[1];
      run.data[2] = enc_a.b[2];
      run.data[3] = enc_b.b[0];
      run.data[4] = enc_b.b[1];
      run.data[5] = enc_b.b[2];
      run.data[6] = enc_b.b[3];
      run.ndata   = RES_IDX_W'(nb) + RES_IDX_W'(3);
    end else begin
      run.data[0] = enc_b.b[0];
      run.data[1] = enc_b.b[1];
      run.data[2] = enc_b.b[2];
      run.data[3] = enc_b.b[3];
      run.ndata   = RES_IDX_W'(nb);
    end
    run.fin   = fin;
    run.fstat = fstat;
  end

  // Buffer state registers, updated as each request is decoded.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aw_r  <= 1'b1;
      ord_r <= 1'b0;
      hp_r  <= 1'b0;
      hb_r  <= '0;
      bw_r  <= '0;
      stp_r <= 1'b0;
    end else if (load) begin
      aw_r  <= aw_nxt;
      ord_r <= ord_nxt;
      hp_r  <= hp_nxt;
      hb_r  <= hb_nxt;
      bw_r  <= bw_nxt;
      stp_r <= stp_nxt;
    end
  end

endmodule

// ===== rtl/core/u16u8_drain.sv =====
// Result register: holds one decoded run and hands out its results one per cycle while out_stall is low.
// Depends on u16u8_pkg.
module u16u8_drain (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  u16u8_pkg::run_t   run,
  output logic              ready,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_byte,
  output logic              out_byte_valid,
  output logic [1:0]        out_status,
  output logic              out_last_of_run
);
  import u16u8_pkg::*;

  run_t                 run_r;
  logic [RES_IDX_W-1:0] cnt_r, cnt_nxt;
  logic [RES_IDX_W-1:0] idx_r, idx_nxt;
  logic                 last_slot;
  logic                 take;

  // Current result comes straight from the held run.
  always_comb begin
    out_valid       = (idx_r < cnt_r);
    last_slot       = (idx_r == cnt_r - RES_IDX_W'(1));
    out_last_of_run = last_slot;
    out_byte_valid  = (idx_r < run_r.ndata);
    out_byte        = out_byte_valid ? run_r.data[idx_r[2:0]] : 8'd0;
    out_status      = out_byte_valid ? ST_RUNNING : run_r.fstat;
    take            = out_valid && !out_stall;
    ready           = !out_valid || (take && last_slot);
  end

  // Advance through the run, or take a new one.
  always_comb begin
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    if (load) begin
      cnt_nxt = run.ndata + RES_IDX_W'(run.fin);
      idx_nxt = '0;
    end else if (take) begin
      if (last_slot) begin
        cnt_nxt = '0;
        idx_nxt = '0;
      end else begin
        idx_nxt = idx_r + RES_IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      idx_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
    end
  end

  // Run payload needs no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      run_r <= run;
    end
  end

endmodule

// ===== rtl/core/utf16_to_utf8_transcoder.sv =====
// UTF-16 to UTF-8 transcoder top level: configuration registers, input register,
// decode stage and result register. Depends on u16u8_pkg, u16u8_step, u16u8_drain.
//
// Usage:
//   Each input request carries one UTF-16 unit as two raw bytes plus first_unit and
//   last_unit flags. Each output request carries one UTF-8 byte, or a status-only
//   result (byte_valid low) that closes the buffer as finished valid or invalid.
//   last_of_run marks the final result caused by one input request.
//   Both channels use valid/stall; a request moves when valid is high and stall low.
//   Flow: a request passes through the input register and the decode stage into the
//   result register, from which its first result appears on the output.
//   Throughput: a request causes N results (N from 0 to 7), which the result register
//   hands out one per cycle while out_stall is low; requests with one result flow at
//   one per cycle while out_stall is low, and requests with no result take no output
//   slot. The input register accepts the next request while results still drain.
//   Stalls on the output hold the current result unchanged and back up into
//   in_stall once the input register is occupied. Reset clears the handshakes and
//   state, sets byte order to detect-from-mark and capacity to 65535. The user must
//   write configuration through cfg_we/cfg_index/cfg_data only while the block is
//   idle; the block itself does not enforce it. Byte order is taken at each buffer start.
module utf16_to_utf8_transcoder #(
  parameter int COUNT_WIDTH = u16u8_pkg::COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_first_byte,
  input  logic [7:0]  in_second_byte,
  input  logic        in_first_unit,
  input  logic        in_last_unit,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_byte_valid,
  output logic [1:0]  out_status,
  output logic        out_last_of_run
);
  import u16u8_pkg::*;

  logic [1:0]  mode_r;
  logic [15:0] cap_r;
  logic        in_vld_r;
  logic [7:0]  b1_r, b2_r;
  logic        fu_r, lu_r;
  logic        drain_ready;
  logic        load;
  run_t        run;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_DETECT;
      cap_r  <= 16'hFFFF;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BYTE_ORDER_MODE: mode_r <= cfg_data[1:0];
        REG_OUT_CAPACITY:    cap_r  <= cfg_data;
        default:             mode_r <= mode_r;
      endcase
    end
  end

  // Input register: emptied whenever the decode stage hands a run to the output.
  assign load     = in_vld_r && drain_ready;
  assign in_stall = in_vld_r && !drain_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      b1_r <= in_first_byte;
      b2_r <= in_second_byte;
      fu_r <= in_first_unit;
      lu_r <= in_last_unit;
    end
  end

  // Decode stage with the buffer state.
  u16u8_step #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_step (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .first_byte (b1_r),
    .second_byte(b2_r),
    .first_unit (fu_r),
    .last_unit  (lu_r),
    .mode       (mode_r),
    .capacity   (cap_r),
    .run        (run)
  );

  // Result register and serializer.
  u16u8_drain u_drain (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (load),
    .run            (run),
    .ready          (drain_ready),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_status     (out_status),
    .out_last_of_run(out_last_of_run)
  );

endmodule

// ===== dv/utf8_stream_checker.sv =====
// Checker for the UTF-16 to UTF-8 transcoder: watches both channels and the register port,
// predicts the UTF-8 result stream and compares it result by result.
// Depends on u16u8_pkg for register indexes, byte-order modes, status codes and mark bytes.
`timescale 1ns / 1ps

module utf8_stream_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_first_byte,
  input  logic [7:0]  in_second_byte,
  input  logic        in_first_unit,
  input  logic        in_last_unit,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_byte,
  input  logic        out_byte_valid,
  input  logic [1:0]  out_status,
  input  logic        out_last_of_run,
  output int          fail_count,
  output int          n_waiting
);
  import u16u8_pkg::*;

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       dvalid;
    logic [1:0] stat;
    logic       is_last;
  } utf8_res_t;

  // Shadow of the configuration registers.
  logic [1:0]  mode_reg;
  logic [15:0] cap_reg;

  // Shadow of the decoder state.
  logic        order_little;
  logic        mark_wait;
  logic        hi_pend;
  logic [9:0]  hi_bits;
  logic [15:0] nwritten;
  logic        halted;

  // Results of the request being predicted, and all results still owed by the block.
  utf8_res_t   run_buf[$];
  utf8_res_t   utf8_expected_q[$];

  initial begin
    fail_count = 0;
    n_waiting  = 0;
  end

  function automatic void start_buffer();
    mark_wait    = (mode_reg >= MODE_DETECT);
    order_little = (mode_reg == MODE_LITTLE);
    hi_pend      = 1'b0;
    hi_bits      = '0;
    nwritten     = '0;
    halted       = 1'b0;
  endfunction

  function automatic void add_result(input logic [7:0] d, input logic v, input logic [1:0] s);
    utf8_res_t r;
    r.data    = d;
    r.dvalid  = v;
    r.stat    = s;
    r.is_last = 1'b0;
    run_buf.push_back(r);
  endfunction

  // Status-only result that closes the buffer.
  function automatic void close_buffer(input logic [1:0] s);
    add_result(8'h00, 1'b0, s);
    halted  = 1'b1;
    hi_pend = 1'b0;
  endfunction

  // Encodes one code point; writes nothing and returns 0 when capacity would be reached.
  function automatic bit emit_code(input logic [20:0] cp);
    int unsigned nb;
    logic [7:0]  lead;
    if (cp < 21'h80) begin
      nb = 1; lead = 8'h00;
    end else if (cp < 21'h800) begin
      nb = 2; lead = 8'hC0;
    end else if (cp < 21'h10000) begin
      nb = 3; lead = 8'hE0;
    end else begin
      nb = 4; lead = 8'hF0;
    end
    if ({1'b0, nwritten} + 17'(nb) >= {1'b0, cap_reg}) return 1'b0;
    add_result(lead | 8'(cp >> (6 * (nb - 1))), 1'b1, ST_RUNNING);
    if (nb >= 4) add_result({2'b10, cp[17:12]}, 1'b1, ST_RUNNING);
    if (nb >= 3) add_result({2'b10, cp[11:6]}, 1'b1, ST_RUNNING);
    if (nb >= 2) add_result({2'b10, cp[5:0]}, 1'b1, ST_RUNNING);
    nwritten = nwritten + 16'(nb);
    return 1'b1;
  endfunction

  // Works out every result one accepted request causes and queues them.
  task automatic predict_utf8(input logic [7:0] b1, input logic [7:0] b2,
                              input logic first, input logic is_last);
    logic [15:0] cu;
    logic [20:0] cp;
    bit          done;
    run_buf.delete();
    done = 1'b0;
    if (first) start_buffer();
    if (!halted) begin
      if (mark_wait) begin
        // The first unit of a detect-mode buffer is consumed as the byte-order mark.
        mark_wait = 1'b0;
        if (b1 == BOM_FF && b2 == BOM_FE) order_little = 1'b1;
        else if (b1 == BOM_FE && b2 == BOM_FF) order_little = 1'b0;
        else close_buffer(ST_INVALID);
        if (!halted && is_last) close_buffer(ST_VALID);
      end else if (b1 == 8'h00 && b2 == 8'h00) begin
        // Zero unit ends the string; a held high surrogate goes out on its own first.
        if (hi_pend) begin
          hi_pend = 1'b0;
          if (!emit_code({5'b0, 6'b110110, hi_bits})) begin
            close_buffer(ST_INVALID);
            done = 1'b1;
          end
        end
        if (!done) close_buffer(ST_VALID);
      end else begin
        cu = order_little ? {b2, b1} : {b1, b2};
        if (hi_pend) begin
          hi_pend = 1'b0;
          if (cu >= 16'hDC00 && cu <= 16'hDFFF) begin
            cp = 21'h10000 + {hi_bits, 10'b0} + 21'(cu - 16'hDC00);
            if (!emit_code(cp)) close_buffer(ST_INVALID);
            else if (is_last) close_buffer(ST_VALID);
            done = 1'b1;
          end else if (!emit_code({5'b0, 6'b110110, hi_bits})) begin
            close_buffer(ST_INVALID);
            done = 1'b1;
          end
        end
        if (!done) begin
          if (cu >= 16'hD800 && cu <= 16'hDBFF) begin
            if (is_last) begin
              close_buffer(ST_INVALID);
            end else begin
              hi_pend = 1'b1;
              hi_bits = cu[9:0];
            end
          end else if (!emit_code({5'b0, cu})) begin
            close_buffer(ST_INVALID);
          end else if (is_last) begin
            close_buffer(ST_VALID);
          end
        end
      end
    end
    if (run_buf.size() > 0) run_buf[run_buf.size() - 1].is_last = 1'b1;
    foreach (run_buf[i]) utf8_expected_q.push_back(run_buf[i]);
  endtask

  // Track registers and requests, then compare each accepted result with the oldest one owed.
  always @(posedge clk) begin
    utf8_res_t want;
    if (!rst_n) begin
      mode_reg = MODE_DETECT;
      cap_reg  = 16'hFFFF;
      start_buffer();
      utf8_expected_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_BYTE_ORDER_MODE) mode_reg = cfg_data[1:0];
        else cap_reg = cfg_data;
      end
      if (in_valid && !in_stall)
        predict_utf8(in_first_byte, in_second_byte, in_first_unit, in_last_unit);
      if (out_valid && !out_stall) begin
        if (utf8_expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("unexpected result: byte=%02h valid=%0b status=%0d last=%0b",
                     out_byte, out_byte_valid, out_status, out_last_of_run);
        end else begin
          want = utf8_expected_q.pop_front();
          if (out_byte !== want.data || out_byte_valid !== want.dvalid ||
              out_status !== want.stat || out_last_of_run !== want.is_last) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
              $display({"result mismatch: expected byte=%02h valid=%0b status=%0d last=%0b,",
                        " got byte=%02h valid=%0b status=%0d last=%0b"},
                       want.data, want.dvalid, want.stat, want.is_last,
                       out_byte, out_byte_valid, out_status, out_last_of_run);
          end
        end
      end
    end
    n_waiting <= utf8_expected_q.size();
  end

endmodule

// ===== dv/tb_utf16_to_utf8_transcoder.sv =====
// Testbench top for the UTF-16 to UTF-8 transcoder: clock, reset, register writes,
// input stimulus and output stalls. Depends on u16u8_pkg, the transcoder and utf8_stream_checker.
`timescale 1ns / 1ps

module tb_utf16_to_utf8_transcoder;
  import u16u8_pkg::*;

  // Mode 3 behaves like detect; it has no name in the package.
  localparam logic [1:0] MODE_DETECT_ALT = 2'd3;
  localparam int PHASE_ITEMS    = 28;
  localparam int HOLD_CYCLES    = 48;
  localparam int TAIL_CYCLES    = 8;
  localparam int WATCHDOG_LIMIT = 4000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_first_byte = '0;
  logic [7:0]  in_second_byte = '0;
  logic        in_first_unit = 1'b0;
  logic        in_last_unit = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        out_byte_valid;
  logic [1:0]  out_status;
  logic        out_last_of_run;

  int          fail_count;
  int          n_waiting;

  int          send_idle_pct = 13;
  int          recv_idle_pct = 69;
  int          hold_asks = 0;
  int          hold_served = 0;
  int          hold_left = 0;
  int          quiet_cycles = 0;
  int          items_sent = 0;
  logic [1:0]  cur_mode = MODE_DETECT;
  logic        cur_little = 1'b0;

  always #1 clk = ~clk;

  utf16_to_utf8_transcoder dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_first_byte   (in_first_byte),
    .in_second_byte  (in_second_byte),
    .in_first_unit   (in_first_unit),
    .in_last_unit    (in_last_unit),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_byte_valid  (out_byte_valid),
    .out_status      (out_status),
    .out_last_of_run (out_last_of_run)
  );

  utf8_stream_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_first_byte   (in_first_byte),
    .in_second_byte  (in_second_byte),
    .in_first_unit   (in_first_unit),
    .in_last_unit    (in_last_unit),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_byte_valid  (out_byte_valid),
    .out_status      (out_status),
    .out_last_of_run (out_last_of_run),
    .fail_count      (fail_count),
    .n_waiting       (n_waiting)
  );

  // Receiver: random stalls, or a long counted hold-off when the stimulus asks for one.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_asks) begin
      hold_served <= hold_asks;
      hold_left   <= HOLD_CYCLES;
      out_stall   <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Watchdog: ends the run when neither channel moves a request for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Offers one request after a random gap and waits until it is accepted.
  task automatic send_unit(input logic [7:0] b1, input logic [7:0] b2,
                           input logic first, input logic is_last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_first_byte  <= b1;
    in_second_byte <= b2;
    in_first_unit  <= first;
    in_last_unit   <= is_last;
    do @(posedge clk); while (!(in_valid && !in_stall));
    items_sent++;
  endtask

  // Sends a 16-bit code unit in the given byte order.
  task automatic send_code_unit(input logic [15:0] cu, input logic little,
                                input logic first, input logic is_last);
    if (little) send_unit(cu[7:0], cu[15:8], first, is_last);
    else send_unit(cu[15:8], cu[7:0], first, is_last);
  endtask

  // Stops offering requests and waits until every owed result has come, plus a short tail.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (n_waiting != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Writes both registers; only called while the block is idle.
  task automatic set_config(input logic [1:0] mode, input logic [15:0] cap);
    cfg_we    <= 1'b1;
    cfg_index <= REG_BYTE_ORDER_MODE;
    cfg_data  <= {14'b0, mode};
    @(posedge clk);
    cfg_index <= REG_OUT_CAPACITY;
    cfg_data  <= cap;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_mode = mode;
  endtask

  // One buffer of random content, mostly well-formed, with some noise and stray flags.
  task automatic send_random_buffer();
    int          len;
    int          pos;
    int          pick;
    logic        first;
    logic        stray;
    logic [15:0] cu;
    len   = $urandom_range(1, 8);
    first = ($urandom_range(99) < 90);
    pos   = 0;
    if (first) begin
      cur_little = (cur_mode == MODE_LITTLE);
      if (cur_mode >= MODE_DETECT) begin
        pick = $urandom_range(99);
        if (pick < 45) begin
          cur_little = 1'b0;
          send_unit(BOM_FE, BOM_FF, 1'b1, len == 1);
        end else if (pick < 90) begin
          cur_little = 1'b1;
          send_unit(BOM_FF, BOM_FE, 1'b1, len == 1);
        end else begin
          send_unit(8'($urandom), 8'($urandom), 1'b1, len == 1);
        end
        pos = 1;
      end
    end
    while (pos < len) begin
      pick = $urandom_range(99);
      if (pick < 25) cu = 16'($urandom_range(16'h0001, 16'h007F));
      else if (pick < 40) cu = 16'($urandom_range(16'h0080, 16'h07FF));
      else if (pick < 55) cu = $urandom_range(1) ? 16'($urandom_range(16'h0800, 16'hD7FF))
                                                 : 16'($urandom_range(16'hE000, 16'hFFFF));
      else if (pick < 80) cu = 16'($urandom_range(16'hD800, 16'hDBFF));
      else if (pick < 85) cu = 16'($urandom_range(16'hDC00, 16'hDFFF));
      else if (pick < 90) cu = 16'h0000;
      else cu = 16'($urandom);
      // Most high surrogates get a low partner when room is left in the buffer.
      if (pick >= 55 && pick < 75 && pos + 1 < len) begin
        send_code_unit(cu, cur_little, first && pos == 0, 1'b0);
        pos++;
        cu = 16'($urandom_range(16'hDC00, 16'hDFFF));
      end
      stray = ($urandom_range(99) < 4);
      send_code_unit(cu, cur_little, first && pos == 0, (pos == len - 1) || stray);
      pos++;
    end
  endtask

  // Stimulus: directed cases, then phases of random buffers under different settings.
  initial begin
    int goal;
    bit held;
    held = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Big-endian mark, then code-length extremes, pairs, lone surrogates and a zero unit.
    send_unit(BOM_FE, BOM_FF, 1'b1, 1'b0);
    send_code_unit(16'h0041, 1'b0, 1'b0, 1'b0);
    send_code_unit(16'h0080, 1'b0, 1'b0, 1'b0);
    send_code_unit(16'h07FF, 1'b0, 1'b0, 1'b0);
    send_code_unit(16'hFFFF, 1'b0, 1'b0, 1'b0);
    send_code_unit(16'hD83D, 1'b0, 1'b0, 1'b0);
    send_code_unit(16'hDE00, 1'b0, 1'b0, 1'b0);
    send_code_unit(16'hDBFF, 1'b0, 1'b0, 1'b0);
    send_code_unit(16'hDFFF, 1'b0, 1'b0, 1'b0);
    send_code_unit(16'hD800, 1'b0, 1'b0, 1'b0);
    send_code_unit(16'h0041, 1'b0, 1'b0, 1'b0);
    send_code_unit(16'hDC00, 1'b0, 1'b0, 1'b0);
    send_code_unit(16'hD800, 1'b0, 1'b0, 1'b0);
    send_code_unit(16'h0000, 1'b0, 1'b0, 1'b0);
    // After the buffer has finished nothing comes out.
    send_code_unit(16'h0041, 1'b0, 1'b0, 1'b0);

    // Little-endian mark; a held high surrogate followed by a high surrogate as last unit.
    send_unit(BOM_FF, BOM_FE, 1'b1, 1'b0);
    send_code_unit(16'h00E9, 1'b1, 1'b0, 1'b0);
    send_code_unit(16'hD801, 1'b1, 1'b0, 1'b0);
    send_code_unit(16'hDBFF, 1'b1, 1'b0, 1'b1);

    // Bad mark, an ignored follow-up, and a good mark that is also the last unit.
    send_unit(8'h12, 8'h34, 1'b1, 1'b0);
    send_code_unit(16'h0041, 1'b0, 1'b0, 1'b0);
    send_unit(BOM_FE, BOM_FF, 1'b1, 1'b1);

    // Capacity reached by a two-byte code.
    wait_idle();
    set_config(MODE_BIG, 16'd3);
    send_code_unit(16'h0041, 1'b0, 1'b1, 1'b0);
    send_code_unit(16'h00E9, 1'b0, 1'b0, 1'b0);

    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      case (ph)
        0: set_config(MODE_DETECT, 16'hFFFF);
        1: set_config(MODE_BIG, 16'd1);
        2: set_config(MODE_LITTLE, 16'($urandom_range(16, 120)));
        3: set_config(MODE_DETECT_ALT, 16'($urandom_range(1, 65535)));
        4: set_config(MODE_BIG, 16'hFFFF);
        default: set_config(2'($urandom_range(0, 3)), 16'($urandom_range(2, 40)));
      endcase
      if (ph < 2) begin
        send_idle_pct = 13;
        recv_idle_pct <= 69;
      end else if (ph < 4) begin
        send_idle_pct = 69;
        recv_idle_pct <= 13;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct <= 0;
      end
      goal = items_sent + PHASE_ITEMS;
      while (items_sent < goal) begin
        // Long receiver hold-off while requests keep coming, so the block backs up.
        if (ph == 4 && !held && items_sent + 25 >= goal) begin
          hold_asks <= hold_asks + 1;
          held = 1'b1;
        end
        send_random_buffer();
      end
    end

    wait_idle();
    if (fail_count == 0 && n_waiting == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
